// File: src/lidar_scan_obstacle_segmenter_unit_assert.svh
// Assertion helpers; the module that uses them has clk and rst in scope.
`ifndef LIDAR_SCAN_OBSTACLE_SEGMENTER_UNIT_ASSERT_SVH
`define LIDAR_SCAN_OBSTACLE_SEGMENTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LSOS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// Next-cycle implication.
`define LSOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

// File: src/lsos_pkg.sv
`default_nettype none
package lsos_pkg;

  localparam int RANGE_W  = 16;
  localparam int BEAR_W   = 16;
  localparam int MAXPTS_W = 12;
  localparam int SLOPE_W  = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic signed [RANGE_W-1:0] range_t;
  typedef logic [BEAR_W-1:0]         bearing_t;

  localparam logic [1:0] REG_INVALID_MARKER   = 2'd0;
  localparam logic [1:0] REG_MAX_GROUP_POINTS = 2'd1;
  localparam logic [1:0] REG_SLOPE_LIMIT      = 2'd2;

  localparam range_t                INVALID_MARKER_RST   = 16'sd0;
  localparam logic [MAXPTS_W-1:0]   MAX_GROUP_POINTS_RST = 12'd64;
  localparam logic [SLOPE_W-1:0]    SLOPE_LIMIT_RST      = 16'd0;

  typedef struct packed {
    range_t                invalid_marker;
    logic [MAXPTS_W-1:0]   max_group_points;
    logic [SLOPE_W-1:0]    slope_limit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: src/lsos_point_if.sv
`default_nettype none
interface lsos_point_if import lsos_pkg::*; ();
  logic     valid;
  logic     ready;
  range_t   range_value;
  bearing_t bearing;
  logic     scan_end;

  modport source (output valid, output range_value, output bearing, output scan_end,
                  input ready);
  modport sink (input valid, input range_value, input bearing, input scan_end,
                output ready);
endinterface
`default_nettype wire

// File: src/lsos_obst_if.sv
`default_nettype none
interface lsos_obst_if import lsos_pkg::*; ();
  logic     valid;
  logic     ready;
  bearing_t obstacle_bearing;
  range_t   obstacle_range;
  logic     final_of_step;

  modport source (output valid, output obstacle_bearing, output obstacle_range,
                  output final_of_step, input ready);
  modport sink (input valid, input obstacle_bearing, input obstacle_range,
                input final_of_step, output ready);
endinterface
`default_nettype wire

// File: src/lidar_scan_obstacle_segmenter_unit.sv
// Range-scan obstacle segmenter. Scan points enter one beat at a time on the
// points channel and are grouped into obstacles; each closed obstacle leaves as
// one beat on the obstacles channel (midpoint of first and last bearing,
// truncated mean range), with final_of_step set on the last beat a point
// causes. A point closes at most two obstacles. The mean range comes from one
// shared restoring divider that retires one quotient bit per cycle over the
// COUNT_BITS+16 bit range sum. A finished mean waits for as long as the output
// register holds a beat that the sink has not taken. The slope test uses one
// registered 16x16 multiply. Points are not taken while a point is in work;
// an obstacle beat may wait in the output register while the next point is taken.
`default_nettype none
`include "lidar_scan_obstacle_segmenter_unit_assert.svh"
module lidar_scan_obstacle_segmenter_unit import lsos_pkg::*; #(
  parameter int COUNT_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  lsos_point_if.sink        points,
  lsos_obst_if.source       obstacles,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SUM_W = COUNT_BITS + RANGE_W;
  localparam int CMP_W = (COUNT_BITS > MAXPTS_W) ? COUNT_BITS : MAXPTS_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_WAIT,
    S_FLUSH
  } state_t;

  cfg_t      cfg;
  div_stat_t div_stat;
  range_t    div_quo;

  state_t                  state;
  range_t                  cur_r;
  bearing_t                cur_b;
  logic                    cur_last;
  logic                    flushed;
  logic                    in_group;
  bearing_t                group_first_bearing;
  range_t                  prior_range;
  bearing_t                prior_bearing;
  logic [COUNT_BITS-1:0]   group_count;
  logic signed [SUM_W-1:0] range_sum;
  logic [31:0]             prod;
  bearing_t                em_bear;
  logic                    em_final;
  logic                    out_valid;
  bearing_t                out_bear;
  range_t                  out_range;
  logic                    out_final;

  logic                    valid_pt;
  bearing_t                db;
  logic [RANGE_W:0]        dr;
  logic [RANGE_W:0]        dr_neg;
  logic [RANGE_W-1:0]      adr;
  logic                    edge_hit;
  logic                    full;
  logic                    split;
  logic                    close_grp;
  logic                    emit1;
  logic                    flush_emit;
  logic                    div_start;
  logic                    out_load;
  logic [BEAR_W:0]         bsum_prior;
  logic [BEAR_W:0]         bsum_cur;
  logic signed [SUM_W-1:0] cur_r_ext;

  lsos_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsos_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (range_sum),
    .divisor  (group_count),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    valid_pt   = cur_r != cfg.invalid_marker;
    db         = cur_b - prior_bearing;
    dr         = {cur_r[RANGE_W-1], cur_r} - {prior_range[RANGE_W-1], prior_range};
    dr_neg     = ~dr + 1'b1;
    adr        = dr[RANGE_W] ? dr_neg[RANGE_W-1:0] : dr[RANGE_W-1:0];
    edge_hit   = (cfg.slope_limit != '0) && ({8'h00, adr, 8'h00} >= prod);
    full       = (CMP_W'(group_count) >= CMP_W'(cfg.max_group_points)) ||
                 (group_count == COUNT_MAX);
    split      = valid_pt && in_group && (edge_hit || full);
    close_grp  = !valid_pt && in_group;
    emit1      = split || close_grp;
    flush_emit = !flushed && cur_last && in_group;
    div_start  = ((state == S_DECIDE) && emit1) || ((state == S_FLUSH) && flush_emit);
    out_load   = (state == S_WAIT) && div_stat.done && (!out_valid || obstacles.ready);
    bsum_prior = {1'b0, group_first_bearing} + {1'b0, prior_bearing};
    bsum_cur   = {1'b0, group_first_bearing} + {1'b0, cur_b};
    cur_r_ext  = SUM_W'(cur_r);
  end

  assign points.ready               = state == S_IDLE;
  assign obstacles.valid            = out_valid;
  assign obstacles.obstacle_bearing = out_bear;
  assign obstacles.obstacle_range   = out_range;
  assign obstacles.final_of_step    = out_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      flushed             <= 1'b0;
      in_group            <= 1'b0;
      group_first_bearing <= '0;
      prior_range         <= '0;
      prior_bearing       <= '0;
      group_count         <= '0;
      range_sum           <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (out_valid && obstacles.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (points.valid) begin
            cur_r    <= points.range_value;
            cur_b    <= points.bearing;
            cur_last <= points.scan_end;
            flushed  <= 1'b0;
            state    <= S_EVAL;
          end
        end
        S_EVAL: begin
          prod  <= 32'(cfg.slope_limit) * 32'(db);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (valid_pt && (!in_group || split)) begin
            in_group            <= 1'b1;
            group_first_bearing <= cur_b;
            group_count         <= COUNT_BITS'(1);
            range_sum           <= cur_r_ext;
          end else if (valid_pt) begin
            group_count <= group_count + 1'b1;
            range_sum   <= range_sum + cur_r_ext;
          end else if (in_group) begin
            in_group    <= 1'b0;
            group_count <= '0;
            range_sum   <= '0;
          end
          prior_range   <= cur_r;
          prior_bearing <= cur_b;
          if (emit1) begin
            em_bear  <= bsum_prior[BEAR_W:1];
            em_final <= !(cur_last && valid_pt);
            state    <= S_WAIT;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_WAIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_bear  <= em_bear;
            out_range <= div_quo;
            out_final <= em_final;
            state     <= flushed ? S_IDLE : S_FLUSH;
          end
        end
        S_FLUSH: begin
          flushed <= 1'b1;
          state   <= S_IDLE;
          if (cur_last) begin
            if (in_group) begin
              em_bear  <= bsum_cur[BEAR_W:1];
              em_final <= 1'b1;
              state    <= S_WAIT;
            end
            in_group            <= 1'b0;
            group_first_bearing <= '0;
            prior_range         <= '0;
            prior_bearing       <= '0;
            group_count         <= '0;
            range_sum           <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LSOS_ASSERT_NEXT(a_busy_after_accept, points.valid && points.ready, !points.ready)
  `LSOS_ASSERT_NOW(a_count_tracks_group, state == S_IDLE, in_group == (group_count != '0))
  `LSOS_ASSERT_NOW(a_div_start_free, div_start, !div_stat.busy)
  `LSOS_ASSERT_NOW(a_load_after_div, out_load, div_stat.done && !div_stat.busy)

endmodule
`default_nettype wire

// File: src/lsos_regs.sv
`default_nettype none
module lsos_regs import lsos_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invalid_marker   <= INVALID_MARKER_RST;
      cfg.max_group_points <= MAX_GROUP_POINTS_RST;
      cfg.slope_limit      <= SLOPE_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_INVALID_MARKER:   cfg.invalid_marker   <= range_t'(pwdata[RANGE_W-1:0]);
        REG_MAX_GROUP_POINTS: cfg.max_group_points <= pwdata[MAXPTS_W-1:0];
        REG_SLOPE_LIMIT:      cfg.slope_limit      <= pwdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INVALID_MARKER:   prdata = DATA_W'(cfg.invalid_marker);
      REG_MAX_GROUP_POINTS: prdata = DATA_W'(cfg.max_group_points);
      REG_SLOPE_LIMIT:      prdata = DATA_W'(cfg.slope_limit);
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/lsos_div.sv
`default_nettype none
module lsos_div import lsos_pkg::*; #(
  parameter int DIVIDEND_W = 28,
  parameter int DIVISOR_W  = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output div_stat_t                    stat,
  output range_t                       quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dsr;
  logic                  neg;
  logic                  done;

  logic [DIVISOR_W:0]    shifted;
  logic                  fits;
  logic [DIVIDEND_W-1:0] mag;
  logic [DIVIDEND_W-1:0] signed_quo;

  assign shifted    = {rem[DIVISOR_W-1:0], quo[DIVIDEND_W-1]};
  assign fits       = shifted >= {1'b0, dsr};
  assign mag        = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = range_t'(signed_quo[RANGE_W-1:0]);
  assign stat.busy  = cnt != '0;
  assign stat.done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(DIVIDEND_W);
      done <= 1'b0;
      rem  <= '0;
      quo  <= mag;
      dsr  <= divisor;
      neg  <= dividend[DIVIDEND_W-1];
    end else if (cnt != '0) begin
      rem <= fits ? (shifted - {1'b0, dsr}) : shifted;
      quo <= {quo[DIVIDEND_W-2:0], fits};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
  import lsos_pkg::*;

  typedef struct packed {
    range_t   range_value;
    bearing_t bearing;
    logic     scan_end;
  } point_t;

  typedef struct packed {
    bearing_t obstacle_bearing;
    range_t   obstacle_range;
    logic     final_of_step;
  } obstacle_t;

  localparam int COUNT_BITS = 12;
  localparam int unsigned COUNT_CAP = (1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_POINTS = 120;
  localparam int LONG_RUN = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;

  lsos_point_if pts();
  lsos_obst_if  obs();

  lidar_scan_obstacle_segmenter_unit #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk), .rst(rst), .points(pts), .obstacles(obs),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  point_t    points_to_send[$];
  obstacle_t expected_obstacles[$];

  range_t          mdl_marker   = INVALID_MARKER_RST;
  logic [11:0]     mdl_max_pts  = MAX_GROUP_POINTS_RST;
  logic [15:0]     mdl_slope    = SLOPE_LIMIT_RST;

  bit          grp_open;
  bearing_t    grp_first;
  range_t      last_range;
  bearing_t    last_bearing;
  int unsigned grp_count;
  int          grp_sum;

  bit no_idle = 1'b0;
  int send_gap, take_gap;
  int points_queued, points_sent, obstacles_seen, errors, phases, cycles;

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_group();
    grp_open = 1'b0;
    grp_first = '0;
    last_range = '0;
    last_bearing = '0;
    grp_count = 0;
    grp_sum = 0;
  endfunction

  function automatic obstacle_t close_group(bearing_t end_bearing);
    obstacle_t o;
    logic [16:0] bsum;
    bsum = {1'b0, grp_first} + {1'b0, end_bearing};
    o.obstacle_bearing = bsum[16:1];
    o.obstacle_range = range_t'(grp_sum / int'(grp_count));
    o.final_of_step = 1'b0;
    return o;
  endfunction

  function automatic void segment_point(point_t p);
    obstacle_t found[$];
    int dr;
    longint unsigned adr, db;
    bearing_t delta;
    bit split;
    if (p.range_value != mdl_marker) begin
      if (!grp_open) begin
        grp_open = 1'b1;
        grp_first = p.bearing;
        grp_count = 1;
        grp_sum = int'(p.range_value);
      end else begin
        dr = int'(p.range_value) - int'(last_range);
        adr = longint'((dr < 0) ? -dr : dr);
        delta = p.bearing - last_bearing;
        db = 64'(delta);
        split = (mdl_slope != 0 && adr * 256 >= longint'(mdl_slope) * db) ||
                grp_count >= mdl_max_pts || grp_count >= COUNT_CAP;
        if (split) begin
          found = {found, close_group(last_bearing)};
          grp_first = p.bearing;
          grp_count = 1;
          grp_sum = int'(p.range_value);
        end else begin
          grp_sum += int'(p.range_value);
          grp_count++;
        end
      end
    end else if (grp_open) begin
      found = {found, close_group(last_bearing)};
      grp_open = 1'b0;
      grp_count = 0;
      grp_sum = 0;
    end
    last_range = p.range_value;
    last_bearing = p.bearing;
    if (p.scan_end) begin
      if (grp_open) found = {found, close_group(p.bearing)};
      clear_group();
    end
    if (found.size() > 0) found[found.size()-1].final_of_step = 1'b1;
    foreach (found[i]) expected_obstacles = {expected_obstacles, found[i]};
  endfunction

  always @(posedge clk) begin : point_driver
    point_t nxt;
    if (rst) begin
      pts.valid <= 1'b0;
      send_gap <= 0;
    end else if (!pts.valid || pts.ready) begin
      if (pts.valid) begin
        segment_point('{pts.range_value, pts.bearing, pts.scan_end});
        points_sent++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        pts.valid <= 1'b0;
      end else if (points_to_send.size() > 0) begin
        nxt = points_to_send.pop_front();
        pts.range_value <= nxt.range_value;
        pts.bearing <= nxt.bearing;
        pts.scan_end <= nxt.scan_end;
        pts.valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        pts.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : obstacle_monitor
    obstacle_t want, got;
    if (rst) begin
      obs.ready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (obs.valid && obs.ready) begin
        got = '{obs.obstacle_bearing, obs.obstacle_range, obs.final_of_step};
        obstacles_seen++;
        if (expected_obstacles.size() == 0) begin
          $display("%0t: expected no beat, actual bearing %0d range %0d final %0b",
                   $time, got.obstacle_bearing, got.obstacle_range, got.final_of_step);
          errors++;
        end else begin
          want = expected_obstacles.pop_front();
          if (got.obstacle_bearing !== want.obstacle_bearing ||
              got.obstacle_range !== want.obstacle_range ||
              got.final_of_step !== want.final_of_step) begin
            $display("%0t: expected b=%0d r=%0d f=%0b, actual b=%0d r=%0d f=%0b",
                     $time, want.obstacle_bearing, want.obstacle_range, want.final_of_step,
                     got.obstacle_bearing, got.obstacle_range, got.final_of_step);
            errors++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        obs.ready <= 1'b0;
      end else begin
        obs.ready <= 1'b1;
        take_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d beats outstanding", $time, expected_obstacles.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_INVALID_MARKER:   mdl_marker = val[15:0];
      REG_MAX_GROUP_POINTS: mdl_max_pts = val[11:0];
      REG_SLOPE_LIMIT:      mdl_slope = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input range_t marker, input logic [11:0] max_pts,
                            input logic [15:0] slope);
    write_reg(REG_INVALID_MARKER, {16'd0, marker});
    write_reg(REG_MAX_GROUP_POINTS, {20'd0, max_pts});
    write_reg(REG_SLOPE_LIMIT, {16'd0, slope});
    phases++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (points_to_send.size() != 0 || pts.valid || expected_obstacles.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic add_point(input range_t r, input bearing_t b, input logic e);
    point_t p;
    p = '{r, b, e};
    points_to_send = {points_to_send, p};
    points_queued++;
  endtask

  task automatic add_scan(input range_t marker);
    int len, level, k, roll;
    bearing_t ang;
    len = $urandom_range(2, 40);
    ang = bearing_t'($urandom);
    level = $urandom_range(0, 65535) - 32768;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 10) level = $urandom_range(0, 65535) - 32768;
      if ($urandom_range(0, 99) < 8) add_point(marker, ang, k == len - 1);
      else add_point(range_t'(level + $urandom_range(0, 60) - 30), ang, k == len - 1);
      roll = $urandom_range(0, 99);
      if (roll < 5) ang = ang;
      else if (roll < 8) ang = ang + bearing_t'($urandom);
      else ang = ang + bearing_t'($urandom_range(1, 300));
    end
  endtask

  initial begin : stimulus
    int ph, start, k, roll;
    range_t marker;
    logic [11:0] max_pts;
    logic [15:0] slope;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clear_group();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: ignore, join at extremes, close on marker, flush
    add_point(16'sd0, 16'd10, 1'b0);
    add_point(16'sh7FFF, 16'd0, 1'b0);
    add_point(16'sh8000, 16'hFFFF, 1'b0);
    add_point(16'sd0, 16'd100, 1'b0);
    add_point(16'sd100, 16'd200, 1'b1);
    add_point(16'sd5, 16'd300, 1'b1);
    add_point(16'sd0, 16'd400, 1'b1);
    drain();

    // zero bearing step, single-point groups, split plus flush
    set_config(16'sh8000, 12'd1, 16'd1);
    add_point(16'sh7FFF, 16'd1000, 1'b0);
    add_point(16'sh7FFF, 16'd1000, 1'b0);
    add_point(-16'sd32767, 16'd1001, 1'b1);
    drain();

    // steepest threshold, bearing wrap, marker at top of range
    set_config(16'sh7FFF, 12'd4095, 16'hFFFF);
    add_point(16'sd10, 16'd65000, 1'b0);
    add_point(16'sd300, 16'd65500, 1'b0);
    add_point(16'sd20, 16'd100, 1'b0);
    add_point(16'sh8000, 16'd101, 1'b0);
    add_point(16'sh7FFF, 16'd102, 1'b0);
    add_point(16'sd1, 16'd103, 1'b1);
    drain();

    // forced split on group size
    set_config(16'sd0, 12'd3, 16'd0);
    for (k = 1; k <= 5; k++) add_point(range_t'(k), bearing_t'(k * 10), k == 5);
    add_point(16'sd7, 16'd50, 1'b1);
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: marker = 16'sd0;
        1: marker = 16'sh8000;
        2: marker = 16'sh7FFF;
        default: marker = range_t'($urandom);
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 50) max_pts = 12'($urandom_range(1, 8));
      else if (roll < 80) max_pts = 12'($urandom_range(9, 64));
      else if (roll < 90) max_pts = 12'd1;
      else max_pts = 12'($urandom_range(1, 4095));
      case ($urandom_range(0, 5))
        0: slope = 16'd0;
        1: slope = 16'd1;
        2: slope = 16'hFFFF;
        3, 4: slope = 16'($urandom_range(64, 4096));
        default: slope = 16'($urandom);
      endcase
      set_config(marker, max_pts, slope);
      no_idle = ($urandom_range(0, 3) == 0);
      start = points_queued;
      while (points_queued - start < PHASE_POINTS) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          add_point(range_t'($urandom), bearing_t'($urandom), $urandom_range(0, 7) == 0);
        end else if (roll == 1) begin
          add_point(marker, bearing_t'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          add_scan(marker);
        end
      end
      drain();
    end

    // one long scan at the largest range for a wide sum and count
    set_config(16'sd0, 12'd4095, 16'd0);
    no_idle = 1'b1;
    for (k = 0; k < LONG_RUN; k++) add_point(16'sh7FFF, bearing_t'(k), k == LONG_RUN - 1);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("points sent %0d, obstacle beats checked %0d, config phases %0d, mismatches %0d",
             points_sent, obstacles_seen, phases, errors);
    $display("covered edge cases, random scans with noise and stalls, and a long wide-sum scan");
    if (errors == 0 && expected_obstacles.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+src
src/lsos_pkg.sv
src/lsos_point_if.sv
src/lsos_obst_if.sv
src/lsos_regs.sv
src/lsos_div.sv
src/lidar_scan_obstacle_segmenter_unit.sv
dv/testbench.sv
